@@ hdl/xoodoo_permutation_defines.svh @@
// Assertion macros for the Xoodoo permutation pipeline.
`ifndef XOODOO_PERMUTATION_DEFINES_SVH
`define XOODOO_PERMUTATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define XOODOO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define XOODOO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/xoodoo_pkg.sv @@
// Types, round constants and the round function of the Xoodoo permutation.
package xoodoo_pkg;

  localparam int TABLE_LEN = 12;

  typedef logic [31:0] word_t;
  typedef logic [2:0][3:0][31:0] state_t;

  localparam word_t ROUND_CONST [TABLE_LEN] = '{
    32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
    32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
    32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
  };

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t round_fn(input state_t a_in, input word_t rc);
    state_t a;
    state_t b;
    logic [3:0][31:0] e;
    word_t p;
    a = a_in;
    // theta
    for (int c = 0; c < 4; c++) begin
      p = a[0][(c + 3) & 3] ^ a[1][(c + 3) & 3] ^ a[2][(c + 3) & 3];
      e[c] = rotl(p, 5) ^ rotl(p, 14);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        a[r][c] = a[r][c] ^ e[c];
      end
    end
    // rho-west
    b = a;
    for (int c = 0; c < 4; c++) begin
      b[1][c] = a[1][(c + 3) & 3];
      b[2][c] = rotl(a[2][c], 11);
    end
    // iota
    b[0][0] = b[0][0] ^ rc;
    // chi
    for (int c = 0; c < 4; c++) begin
      a[0][c] = b[0][c] ^ (~b[1][c] & b[2][c]);
      a[1][c] = b[1][c] ^ (~b[2][c] & b[0][c]);
      a[2][c] = b[2][c] ^ (~b[0][c] & b[1][c]);
    end
    // rho-east
    b[0] = a[0];
    for (int c = 0; c < 4; c++) begin
      b[1][c] = rotl(a[1][c], 1);
      b[2][c] = rotl(a[2][(c + 2) & 3], 8);
    end
    return b;
  endfunction

endpackage

@@ hdl/xoodoo_if.sv @@
// Valid/ready channel interfaces for the permutation input and output states.
interface xoodoo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_r0_c0;
  logic [31:0] in_r0_c1;
  logic [31:0] in_r0_c2;
  logic [31:0] in_r0_c3;
  logic [31:0] in_r1_c0;
  logic [31:0] in_r1_c1;
  logic [31:0] in_r1_c2;
  logic [31:0] in_r1_c3;
  logic [31:0] in_r2_c0;
  logic [31:0] in_r2_c1;
  logic [31:0] in_r2_c2;
  logic [31:0] in_r2_c3;

  modport source (
    output valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r0_c3, in_r1_c0, in_r1_c1,
           in_r1_c2, in_r1_c3, in_r2_c0, in_r2_c1, in_r2_c2, in_r2_c3,
    input  ready
  );
  modport sink (
    input  valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r0_c3, in_r1_c0, in_r1_c1,
           in_r1_c2, in_r1_c3, in_r2_c0, in_r2_c1, in_r2_c2, in_r2_c3,
    output ready
  );
endinterface

interface xoodoo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_r0_c0;
  logic [31:0] out_r0_c1;
  logic [31:0] out_r0_c2;
  logic [31:0] out_r0_c3;
  logic [31:0] out_r1_c0;
  logic [31:0] out_r1_c1;
  logic [31:0] out_r1_c2;
  logic [31:0] out_r1_c3;
  logic [31:0] out_r2_c0;
  logic [31:0] out_r2_c1;
  logic [31:0] out_r2_c2;
  logic [31:0] out_r2_c3;

  modport source (
    output valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r0_c3, out_r1_c0,
           out_r1_c1, out_r1_c2, out_r1_c3, out_r2_c0, out_r2_c1, out_r2_c2,
           out_r2_c3,
    input  ready
  );
  modport sink (
    input  valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r0_c3, out_r1_c0,
           out_r1_c1, out_r1_c2, out_r1_c3, out_r2_c0, out_r2_c1, out_r2_c2,
           out_r2_c3,
    output ready
  );
endinterface

@@ hdl/xoodoo_round_cell.sv @@
// One pipeline cell: a single Xoodoo round followed by the state register.
module xoodoo_round_cell #(
  parameter logic [31:0] RC = 32'h0000_0058
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  xoodoo_pkg::state_t  up_state,
  output logic                dn_valid,
  input  logic                dn_ready,
  output xoodoo_pkg::state_t  dn_state
);
  import xoodoo_pkg::*;

  logic   valid;
  state_t state;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_state = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state <= round_fn(up_state, RC);
    end
  end
endmodule

@@ hdl/xoodoo_permutation.sv @@
// Top level: Xoodoo permutation as a chain of round cells.
//
// Usage:
//   in_ch  (sink)  carries the twelve 32-bit words of a 384-bit state; word
//                  in_rR_cC is plane R, lane C. A transaction is taken when
//                  valid and ready are both high at a rising clk edge.
//   out_ch (source) returns the permuted words out_rR_cC, one transaction
//                  per input transaction, in order.
//   Each of the ROUND_COUNT cells holds one state and applies one round;
//   states move one cell per cycle when the next cell can accept them.
//   out_ch.valid rises once a state has passed all ROUND_COUNT cell
//   registers. Throughput is one state per cycle while out_ch.ready stays
//   high; up to ROUND_COUNT states are in flight.
//   A reduced round count runs the last ROUND_COUNT round constants.
//   rst (synchronous, active high) empties every cell; no state is kept.
//   When the receiver stalls, the last cell holds its result; cells behind
//   it keep filling until every cell is occupied, then in_ch.ready drops.
//   in_ch.ready follows out_ch.ready combinationally through the chain.
`include "xoodoo_permutation_defines.svh"

module xoodoo_permutation #(
  parameter int ROUND_COUNT = 12
) (
  input logic           clk,
  input logic           rst,
  xoodoo_in_if.sink     in_ch,
  xoodoo_out_if.source  out_ch
);
  import xoodoo_pkg::*;

  logic   [ROUND_COUNT:0] vld;
  logic   [ROUND_COUNT:0] rdy;
  state_t                 st [ROUND_COUNT+1];

  assign vld[0]    = in_ch.valid;
  assign in_ch.ready = rdy[0];
  assign st[0][0][0] = in_ch.in_r0_c0;
  assign st[0][0][1] = in_ch.in_r0_c1;
  assign st[0][0][2] = in_ch.in_r0_c2;
  assign st[0][0][3] = in_ch.in_r0_c3;
  assign st[0][1][0] = in_ch.in_r1_c0;
  assign st[0][1][1] = in_ch.in_r1_c1;
  assign st[0][1][2] = in_ch.in_r1_c2;
  assign st[0][1][3] = in_ch.in_r1_c3;
  assign st[0][2][0] = in_ch.in_r2_c0;
  assign st[0][2][1] = in_ch.in_r2_c1;
  assign st[0][2][2] = in_ch.in_r2_c2;
  assign st[0][2][3] = in_ch.in_r2_c3;

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_cell
    xoodoo_round_cell #(
      .RC(ROUND_CONST[TABLE_LEN - ROUND_COUNT + k])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_state (st[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_state (st[k+1])
    );
  end

  assign rdy[ROUND_COUNT] = out_ch.ready;
  assign out_ch.valid     = vld[ROUND_COUNT];
  assign out_ch.out_r0_c0 = st[ROUND_COUNT][0][0];
  assign out_ch.out_r0_c1 = st[ROUND_COUNT][0][1];
  assign out_ch.out_r0_c2 = st[ROUND_COUNT][0][2];
  assign out_ch.out_r0_c3 = st[ROUND_COUNT][0][3];
  assign out_ch.out_r1_c0 = st[ROUND_COUNT][1][0];
  assign out_ch.out_r1_c1 = st[ROUND_COUNT][1][1];
  assign out_ch.out_r1_c2 = st[ROUND_COUNT][1][2];
  assign out_ch.out_r1_c3 = st[ROUND_COUNT][1][3];
  assign out_ch.out_r2_c0 = st[ROUND_COUNT][2][0];
  assign out_ch.out_r2_c1 = st[ROUND_COUNT][2][1];
  assign out_ch.out_r2_c2 = st[ROUND_COUNT][2][2];
  assign out_ch.out_r2_c3 = st[ROUND_COUNT][2][3];

  `XOODOO_ASSERT_NOW(a_full_when_blocked, !in_ch.ready, $countones(vld[ROUND_COUNT:1]) == ROUND_COUNT, "input blocked while a cell is empty")
  `XOODOO_ASSERT_NOW(a_ready_propagates, out_ch.ready, in_ch.ready, "downstream ready not reaching input")
  `XOODOO_ASSERT_NEXT(a_accept_fills, in_ch.valid && in_ch.ready, vld[1], "accepted transaction lost at first cell")
  `XOODOO_ASSERT_NEXT(a_stall_holds, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped under stall")
endmodule
